### rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequence is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lfu_pkg.sv
// shared types and constants of the lfu cache table
package lfu_pkg;
    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 8;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int CAP_W          = 5;
    localparam int CAP_RESET      = 16;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // capture input beat, clear scan results
        logic scan;     // examine entry at scan index
        logic scan_clr; // reset scan index
        logic commit;   // apply update to entry
        logic adjust;   // apply rank adjustment at scan index
    } lfu_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;
        logic hit;
        logic kind;
        logic cap_zero;
        logic full;
        logic have_victim;
        logic have_free;
    } lfu_sts_t;
endpackage

### rtl/lfu_datapath.sv
// entry table, scan index and rank update logic of the lfu cache table
`include "assert_macros.svh"
module lfu_datapath import lfu_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lfu_cmd_t                cmd,
    output lfu_sts_t                sts,
    input  logic [CAP_W-1:0]        capacity,
    input  logic                    in_kind,
    input  logic [KEY_W-1:0]        in_key,
    input  logic signed [VAL_W-1:0] in_value,
    output logic                    res_found,
    output logic signed [VAL_W-1:0] res_value
);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [ENTRIES-1:0]    valid_reg;
    logic [KEY_W-1:0]      key_reg   [ENTRIES];
    logic [VAL_W-1:0]      value_reg [ENTRIES];
    logic [COUNT_BITS-1:0] count_reg [ENTRIES];
    logic [IDX_W-1:0]      rank_reg  [ENTRIES];
    logic [FILL_W-1:0]     fill_reg;

    logic                  kind_reg;
    logic [KEY_W-1:0]      lkey_reg;
    logic [VAL_W-1:0]      wval_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic                  vic_ok_reg;
    logic [IDX_W-1:0]      vic_idx_reg;
    logic [COUNT_BITS-1:0] vic_cnt_reg;
    logic [IDX_W-1:0]      vic_rank_reg;
    logic                  free_ok_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    // adjustment pass parameters
    logic [IDX_W-1:0]      slot_reg;
    logic [IDX_W-1:0]      old_rank_reg;
    logic [1:0]            mode_reg;   // 0 touch, 1 insert, 2 evict+insert
    logic                  do_adj_reg;

    logic [FILL_W-1:0] cap_eff;
    logic              full;
    logic              v_i;
    logic              better;

    assign cap_eff = (32'(capacity) > 32'(ENTRIES)) ? FILL_W'(ENTRIES)
                                                    : FILL_W'(capacity);
    assign full = fill_reg >= cap_eff;
    assign v_i  = valid_reg[idx_reg];
    assign better = !vic_ok_reg || (count_reg[idx_reg] < vic_cnt_reg) ||
                    (count_reg[idx_reg] == vic_cnt_reg && rank_reg[idx_reg] > vic_rank_reg);

    assign sts.scan_last   = idx_reg == IDX_W'(ENTRIES - 1);
    assign sts.hit         = hit_reg;
    assign sts.kind        = kind_reg;
    assign sts.cap_zero    = capacity == '0;
    assign sts.full        = full;
    assign sts.have_victim = vic_ok_reg;
    assign sts.have_free   = free_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
            do_adj_reg <= 1'b0;
        end else begin
            if (cmd.scan_clr) begin
                idx_reg <= '0;
            end else if (cmd.scan || cmd.adjust) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.load) begin
                kind_reg    <= in_kind;
                lkey_reg    <= in_key;
                wval_reg    <= in_value;
                hit_reg     <= 1'b0;
                vic_ok_reg  <= 1'b0;
                free_ok_reg <= 1'b0;
                do_adj_reg  <= 1'b0;
            end
            if (cmd.scan && v_i) begin
                if (key_reg[idx_reg] == lkey_reg && !hit_reg) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= idx_reg;
                    res_value   <= value_reg[idx_reg];
                end
                if (better) begin
                    vic_ok_reg   <= 1'b1;
                    vic_idx_reg  <= idx_reg;
                    vic_cnt_reg  <= count_reg[idx_reg];
                    vic_rank_reg <= rank_reg[idx_reg];
                end
            end
            if (cmd.scan && !v_i && !free_ok_reg) begin
                free_ok_reg  <= 1'b1;
                free_idx_reg <= idx_reg;
            end
            if (cmd.commit) begin
                do_adj_reg <= 1'b1;
                if (hit_reg) begin
                    if (kind_reg == KIND_PUT) begin
                        value_reg[hit_idx_reg] <= wval_reg;
                    end
                    if (count_reg[hit_idx_reg] != COUNT_MAX) begin
                        count_reg[hit_idx_reg] <= count_reg[hit_idx_reg] + COUNT_BITS'(1);
                    end
                    slot_reg     <= hit_idx_reg;
                    old_rank_reg <= rank_reg[hit_idx_reg];
                    mode_reg     <= 2'd0;
                end else if (full) begin
                    key_reg[vic_idx_reg]   <= lkey_reg;
                    value_reg[vic_idx_reg] <= wval_reg;
                    count_reg[vic_idx_reg] <= COUNT_BITS'(1);
                    slot_reg     <= vic_idx_reg;
                    old_rank_reg <= vic_rank_reg;
                    mode_reg     <= 2'd2;
                end else begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    key_reg[free_idx_reg]   <= lkey_reg;
                    value_reg[free_idx_reg] <= wval_reg;
                    count_reg[free_idx_reg] <= COUNT_BITS'(1);
                    fill_reg     <= fill_reg + FILL_W'(1);
                    slot_reg     <= free_idx_reg;
                    mode_reg     <= 2'd1;
                end
            end
            if (cmd.adjust && do_adj_reg && valid_reg[idx_reg]) begin
                if (idx_reg == slot_reg) begin
                    rank_reg[idx_reg] <= '0;
                end else begin
                    case (mode_reg)
                        2'd0: if (rank_reg[idx_reg] < old_rank_reg)
                                  rank_reg[idx_reg] <= rank_reg[idx_reg] + IDX_W'(1);
                        2'd1: rank_reg[idx_reg] <= rank_reg[idx_reg] + IDX_W'(1);
                        default: if (rank_reg[idx_reg] < old_rank_reg)
                                  rank_reg[idx_reg] <= rank_reg[idx_reg] + IDX_W'(1);
                    endcase
                end
            end
        end
    end

    assign res_found = hit_reg;

    `ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_W'(ENTRIES),
        "fill count above entry count")
    `ASSERT_NEXT(a_commit_adj, aclk, aresetn, cmd.commit, do_adj_reg,
        "commit did not arm rank pass")
    `ASSERT_IMPL(a_load_scan, aclk, aresetn, cmd.load, !cmd.scan && !cmd.commit,
        "load overlaps scan or commit")
endmodule

### rtl/lfu_ctrl.sv
// sequencing state machine of the lfu cache table
`include "assert_macros.svh"
module lfu_ctrl import lfu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output lfu_cmd_t cmd,
    input  lfu_sts_t sts
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_ADJ    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       upd;

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    // update needed: any get hit, or with nonzero capacity a put hit or put insert
    assign upd = !sts.cap_zero || (sts.kind == KIND_GET)
        ? (sts.hit || (sts.kind == KIND_PUT &&
                       (sts.full ? sts.have_victim : sts.have_free)))
        : 1'b0;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) begin
                cmd.load = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.scan_clr = 1'b1;
                cmd.commit = upd;
                state_next = upd ? ST_ADJ : ST_OUT;
            end
            ST_ADJ: begin
                cmd.adjust = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: if (out_ready) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_IMPL(a_one_side, aclk, aresetn, 1'b1, !(in_ready && out_valid),
        "input and output open together")
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid && !out_ready, out_valid,
        "result dropped under stall")
endmodule

### rtl/lfu_cache_table.sv
// top level of the lfu cache table
// Key-value table with least-frequently-used replacement, ties broken toward the
// least recently touched entry. Operations run one at a time: an accept state, a key
// and victim scan that walks the entry table one entry per cycle, a decide state, a
// rank update walk over all entries when the table changes, and an output state that
// holds under a stall. A get miss or an ignored put skips the rank update walk. Valid
// bits clear at reset.
`include "assert_macros.svh"
module lfu_cache_table import lfu_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,     // capacity[4:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,      // lookup_key[31:0], write_value[63:32]
    input  logic        s_tuser,      // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // read_value[31:0]
    output logic        m_tuser       // found
);
    logic [CAP_W-1:0] cap_reg;
    lfu_cmd_t cmd;
    lfu_sts_t sts;
    logic signed [VAL_W-1:0] rv;
    logic fnd;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_W'(CAP_RESET);
        end else if (cfg_valid) begin
            cap_reg <= cfg_data[CAP_W-1:0];
        end
    end

    lfu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    lfu_datapath #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .capacity(cap_reg), .in_kind(s_tuser),
        .in_key(s_tdata[31:0]), .in_value(s_tdata[63:32]),
        .res_found(fnd), .res_value(rv)
    );

    assign m_tuser = fnd;
    assign m_tdata = (fnd && sts.kind == KIND_GET) ? rv : '0;
endmodule
